@@ design/bft_pkg.sv @@
// Package for the blast front table: codes, register map, fixed-point constants,
// step counts and the state type. Used by blast_front_table; depends on nothing.
`default_nettype none
package bft_pkg;

    localparam int MAX_FRONTS_DEF = 32;
    localparam int PADDR_W        = 5;

    // input kinds
    localparam logic [1:0] KIND_SPAWN  = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // result status codes
    localparam logic [2:0] ST_SPAWNED = 3'd0;
    localparam logic [2:0] ST_EVICTED = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_KEPT    = 3'd3;
    localparam logic [2:0] ST_RETIRED = 3'd4;
    localparam logic [2:0] ST_FOUND   = 3'd5;
    localparam logic [2:0] ST_ABSENT  = 3'd6;
    localparam logic [2:0] ST_EMPTY   = 3'd7;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ENERGY_SCALE   = 3'd0;
    localparam logic [2:0] REG_AIR_DENSITY    = 3'd1;
    localparam logic [2:0] REG_BLAST_CONSTANT = 3'd2;
    localparam logic [2:0] REG_SOUND_SPEED    = 3'd3;
    localparam logic [2:0] REG_PRESSURE_GAIN  = 3'd4;
    localparam logic [2:0] REG_MAX_RADIUS     = 3'd5;

    localparam logic [31:0] RST_ONE = 32'h0001_0000;
    localparam logic [31:0] RST_ALL = 32'hFFFF_FFFF;

    // Q16.16 constants
    localparam logic [31:0] E_REJECT_MAX = 32'd6;
    localparam logic [31:0] E_FLOOR      = 32'd7;
    localparam logic [31:0] XI_FLOOR     = 32'd3277;
    localparam logic [31:0] C0_FLOOR     = 32'd65536;
    localparam logic [48:0] DEN_BIAS     = 49'd655;
    localparam logic [63:0] FADE_DP      = 64'd1311;
    localparam logic [31:0] FADE_R       = 32'd19660;

    localparam logic [5:0] DIV_STEPS  = 6'd48;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SP_MUL,
        S_SP_CHK,
        S_SP_RD,
        S_SP_CMP,
        S_SP_WR,
        S_Q_RD,
        S_Q_CMP,
        S_U_START,
        S_U_SCAN,
        S_U_LOAD,
        S_U_DQ,
        S_U_S1,
        S_U_S2,
        S_U_K,
        S_U_DH,
        S_U_TTR,
        S_U_S3,
        S_U_R1,
        S_U_R2,
        S_U_NUM,
        S_U_RR,
        S_U_DEN,
        S_U_CMP,
        S_U_OUT
    } t_state;

endpackage
`default_nettype wire

@@ design/blast_front_table.sv @@
// Blast front table: spawn, update and query of Sedov-Taylor fronts, one
// shift-subtract unit (division and square root) and one multiplier shared.
// Depends on bft_pkg.
// Spawn writes a free slot, or first searches every slot for the oldest front
// when the table is full. Query scans the slots until the id matches. Update
// runs the shift-subtract unit for each live front (two 48-step divisions,
// three 32-step roots) and steps over free slots. One item at a time.
// Synchronous active-low reset clears the table valid bits, the id counter
// (to one) and the registers to their defaults; slot storage is not cleared.
`default_nettype none
module blast_front_table
    import bft_pkg::*;
#(
    parameter int MAX_FRONTS = MAX_FRONTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [31:0]        i_now_time,
    input  wire logic signed [31:0] i_raw_energy,
    input  wire logic [31:0]        i_query_id,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_status,
    output logic [31:0]             o_front_id,
    output logic [31:0]             o_radius,
    output logic                    o_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = (MAX_FRONTS > 1) ? $clog2(MAX_FRONTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FRONTS - 1);

    // configuration
    logic [31:0] r_scale, r_rho, r_xi, r_c0, r_kp, r_rmax;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= RST_ONE;
            r_rho   <= RST_ONE;
            r_xi    <= RST_ONE;
            r_c0    <= RST_ONE;
            r_kp    <= RST_ONE;
            r_rmax  <= RST_ALL;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENERGY_SCALE:   r_scale <= pwdata;
                REG_AIR_DENSITY:    r_rho   <= pwdata;
                REG_BLAST_CONSTANT: r_xi    <= pwdata;
                REG_SOUND_SPEED:    r_c0    <= pwdata;
                REG_PRESSURE_GAIN:  r_kp    <= pwdata;
                REG_MAX_RADIUS:     r_rmax  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ENERGY_SCALE:   prdata = r_scale;
            REG_AIR_DENSITY:    prdata = r_rho;
            REG_BLAST_CONSTANT: prdata = r_xi;
            REG_SOUND_SPEED:    prdata = r_c0;
            REG_PRESSURE_GAIN:  prdata = r_kp;
            REG_MAX_RADIUS:     prdata = r_rmax;
            default:            prdata = '0;
        endcase
    end

    logic [31:0] rho_f, xi_f, c0_f;
    assign rho_f = (r_rho == '0) ? 32'd1 : r_rho;
    assign xi_f  = (r_xi < XI_FLOOR) ? XI_FLOOR : r_xi;
    assign c0_f  = (r_c0 < C0_FLOOR) ? C0_FLOOR : r_c0;

    // state
    t_state r_state, n_state;

    logic [31:0] r_now, r_raw, r_qid;
    logic        accept;

    logic [MAX_FRONTS-1:0] r_valid;
    logic [31:0]           r_id_ctr;
    logic [IW-1:0]         r_idx, r_best;
    logic [31:0]           r_best_birth;
    logic                  r_evict;

    // slot storage
    logic [31:0] r_mem_id    [MAX_FRONTS];
    logic [31:0] r_mem_birth [MAX_FRONTS];
    logic [31:0] r_mem_energy[MAX_FRONTS];
    logic [31:0] r_mem_rad   [MAX_FRONTS];
    logic [31:0] r_rd_id, r_rd_birth, r_rd_energy, r_rd_rad;

    // update datapath
    logic [31:0] r_e, r_t, r_k, r_rad;
    logic [47:0] r_ttr, r_term, r_num;
    logic [48:0] r_den;
    logic        r_coast, r_retire;

    // shared multiplier
    logic        mul_en;
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_mul;

    // shared shift-subtract unit
    logic        u_start, u_div;
    logic [63:0] u_acc;
    logic [32:0] u_dvsr;
    logic [63:0] r_uacc;
    logic [35:0] r_urem;
    logic [47:0] r_ures;
    logic [5:0]  r_ucnt;
    logic        r_udiv;
    logic [32:0] r_udvsr;
    logic        u_done;
    logic [35:0] rem_sh, trial, rem_nx;
    logic        ge;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [31:0] r_front_id, r_radius;
    logic        r_last;
    logic        emit_ok, emit, emit_last;
    logic [2:0]  emit_st;
    logic [31:0] emit_id, emit_rad;

    // misc combinational
    logic [31:0]   e_spawn;
    logic [IW-1:0] free_idx;
    logic          table_full, more_above, q_match;
    logic [31:0]   id_next;
    logic          wr_new, wr_rad;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign emit_ok = !r_out_valid || !i_stall;
    assign u_done  = (r_ucnt == '0);

    assign e_spawn = r_raw[31] ? 32'd0 :
                     ((|r_mul[63:48]) ? RST_ALL : r_mul[47:16]);
    assign table_full = &r_valid;
    assign id_next    = (r_id_ctr + 32'd1 == '0) ? 32'd1 : r_id_ctr + 32'd1;
    assign q_match    = r_valid[r_idx] && (r_rd_id == r_qid);

    always_comb begin
        free_idx = '0;
        for (int j = MAX_FRONTS - 1; j >= 0; j--) begin
            if (!r_valid[j]) free_idx = IW'(j);
        end
    end

    always_comb begin
        more_above = 1'b0;
        for (int j = 0; j < MAX_FRONTS; j++) begin
            if ((j > int'(r_idx)) && r_valid[j]) more_above = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_SPAWN:  n_state = S_SP_MUL;
                        KIND_UPDATE: n_state = S_U_START;
                        KIND_QUERY:  n_state = S_Q_RD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SP_MUL: n_state = S_SP_CHK;
            S_SP_CHK: begin
                if (e_spawn <= E_REJECT_MAX) begin
                    if (emit_ok) n_state = S_IDLE;
                end else if (table_full) begin
                    n_state = S_SP_RD;
                end else begin
                    n_state = S_SP_WR;
                end
            end
            S_SP_RD:  n_state = S_SP_CMP;
            S_SP_CMP: n_state = (r_idx == LAST_IDX) ? S_SP_WR : S_SP_RD;
            S_SP_WR:  if (emit_ok) n_state = S_IDLE;
            S_Q_RD:   n_state = S_Q_CMP;
            S_Q_CMP: begin
                if (q_match || r_idx == LAST_IDX) begin
                    if (emit_ok) n_state = S_IDLE;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_U_START: begin
                if (r_valid == '0) begin
                    if (emit_ok) n_state = S_IDLE;
                end else begin
                    n_state = S_U_SCAN;
                end
            end
            S_U_SCAN: begin
                if (r_valid[r_idx])          n_state = S_U_LOAD;
                else if (r_idx == LAST_IDX)  n_state = S_IDLE;
            end
            S_U_LOAD: n_state = S_U_DQ;
            S_U_DQ:   if (u_done) n_state = S_U_S1;
            S_U_S1:   if (u_done) n_state = S_U_S2;
            S_U_S2:   if (u_done) n_state = S_U_K;
            S_U_K:    n_state = S_U_DH;
            S_U_DH:   if (u_done) n_state = S_U_TTR;
            S_U_TTR:  n_state = S_U_S3;
            S_U_S3:   if (u_done) n_state = S_U_R1;
            S_U_R1:   n_state = r_coast ? S_U_R2 : S_U_NUM;
            S_U_R2:   n_state = S_U_NUM;
            S_U_NUM:  n_state = S_U_RR;
            S_U_RR:   n_state = S_U_DEN;
            S_U_DEN:  n_state = S_U_CMP;
            S_U_CMP:  n_state = S_U_OUT;
            S_U_OUT: begin
                if (emit_ok) n_state = more_above ? S_U_SCAN : S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        u_start   = 1'b0;
        u_div     = 1'b0;
        u_acc     = '0;
        u_dvsr    = '0;
        emit      = 1'b0;
        emit_st   = ST_REJECT;
        emit_id   = '0;
        emit_rad  = '0;
        emit_last = 1'b1;
        wr_new    = 1'b0;
        wr_rad    = 1'b0;
        unique case (r_state)
            S_SP_MUL: begin
                mul_en = 1'b1;
                mul_a  = r_raw;
                mul_b  = r_scale;
            end
            S_SP_CHK: begin
                if (e_spawn <= E_REJECT_MAX) emit = emit_ok;
            end
            S_SP_WR: begin
                emit    = emit_ok;
                wr_new  = emit_ok;
                emit_st = r_evict ? ST_EVICTED : ST_SPAWNED;
                emit_id = r_id_ctr;
            end
            S_Q_CMP: begin
                if (q_match || r_idx == LAST_IDX) emit = emit_ok;
                emit_st  = q_match ? ST_FOUND : ST_ABSENT;
                emit_id  = r_qid;
                emit_rad = q_match ? r_rd_rad : 32'd0;
            end
            S_U_START: begin
                if (r_valid == '0) emit = emit_ok;
                emit_st = ST_EMPTY;
            end
            S_U_LOAD: begin
                u_start = 1'b1;
                u_div   = 1'b1;
                u_acc   = {((r_rd_energy < E_FLOOR) ? E_FLOOR : r_rd_energy), 32'h0};
                u_dvsr  = {1'b0, rho_f};
            end
            S_U_DQ: begin
                u_start = u_done;
                u_acc   = {r_ures, 16'h0};
            end
            S_U_S1: begin
                u_start = u_done;
                u_acc   = {16'h0, r_ures[31:0], 16'h0};
            end
            S_U_S2, S_U_S3: begin
                mul_en = 1'b1;
                mul_a  = (r_state == S_U_S2) ? xi_f : r_k;
                mul_b  = r_ures[31:0];
            end
            S_U_K: begin
                u_start = 1'b1;
                u_div   = 1'b1;
                u_acc   = {((|r_mul[63:48]) ? RST_ALL : r_mul[47:16]), 32'h0};
                u_dvsr  = {c0_f, 1'b0};
            end
            S_U_DH: begin
                mul_en = 1'b1;
                mul_a  = r_ures[31:0];
                mul_b  = r_ures[31:0];
            end
            S_U_TTR: begin
                u_start = 1'b1;
                // pick the root of elapsed time or of the transition time
                if ({16'h0, r_t} <= r_mul[63:16]) u_acc = {16'h0, r_t, 16'h0};
                else                              u_acc = {r_mul[63:16], 16'h0};
            end
            S_U_R1: begin
                mul_en = 1'b1;
                mul_a  = c0_f;
                mul_b  = r_t - r_ttr[31:0];
            end
            S_U_NUM: begin
                mul_en = 1'b1;
                mul_a  = r_kp;
                mul_b  = r_e;
            end
            S_U_RR: begin
                mul_en = 1'b1;
                mul_a  = r_rad;
                mul_b  = r_rad;
            end
            S_U_OUT: begin
                emit      = emit_ok;
                wr_rad    = emit_ok;
                emit_st   = r_retire ? ST_RETIRED : ST_KEPT;
                emit_id   = r_rd_id;
                emit_rad  = r_rad;
                emit_last = !more_above;
            end
            default: ;
        endcase
    end

    // shift-subtract step: one quotient bit or one root bit per cycle
    always_comb begin
        if (r_udiv) begin
            rem_sh = {r_urem[34:0], r_uacc[63]};
            trial  = {3'b0, r_udvsr};
        end else begin
            rem_sh = {r_urem[33:0], r_uacc[63:62]};
            trial  = {2'b0, r_ures[31:0], 2'b01};
        end
        ge     = (rem_sh >= trial);
        rem_nx = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucnt <= '0;
        end else if (u_start) begin
            r_ucnt <= u_div ? DIV_STEPS : SQRT_STEPS;
        end else if (!u_done) begin
            r_ucnt <= r_ucnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (u_start) begin
            r_uacc  <= u_acc;
            r_urem  <= '0;
            r_ures  <= '0;
            r_udiv  <= u_div;
            r_udvsr <= u_dvsr;
        end else if (!u_done) begin
            r_uacc <= r_udiv ? {r_uacc[62:0], 1'b0} : {r_uacc[61:0], 2'b00};
            r_urem <= rem_nx;
            r_ures <= {r_ures[46:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) r_mul <= {32'h0, mul_a} * {32'h0, mul_b};
    end

    // slot storage, written at r_best (spawn) or r_idx (update); one read address, r_idx
    always_ff @(posedge i_clk) begin
        if (wr_new) begin
            r_mem_id[r_best]     <= r_id_ctr;
            r_mem_birth[r_best]  <= r_now;
            r_mem_energy[r_best] <= r_e;
            r_mem_rad[r_best]    <= '0;
        end else if (wr_rad) begin
            r_mem_rad[r_idx] <= r_rad;
        end
        r_rd_id     <= r_mem_id[r_idx];
        r_rd_birth  <= r_mem_birth[r_idx];
        r_rd_energy <= r_mem_energy[r_idx];
        r_rd_rad    <= r_mem_rad[r_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_id_ctr <= 32'd1;
        end else begin
            r_state <= n_state;
            if (wr_new) begin
                r_valid[r_best] <= 1'b1;
                r_id_ctr        <= id_next;
            end
            if (wr_rad && r_retire) r_valid[r_idx] <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now  <= i_now_time;
            r_raw  <= i_raw_energy;
            r_qid  <= i_query_id;
            r_idx  <= '0;
        end
        case (r_state)
            S_SP_CHK: begin
                r_e      <= e_spawn;
                r_best   <= free_idx;
                r_evict  <= table_full;
                r_idx    <= '0;
            end
            S_SP_CMP: begin
                // strict compare keeps the lowest slot on equal birth times
                if (r_idx == '0 || r_rd_birth < r_best_birth) begin
                    r_best       <= r_idx;
                    r_best_birth <= r_rd_birth;
                end
                if (r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
            end
            S_Q_CMP: begin
                if (!q_match && r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
            end
            S_U_START: r_idx <= '0;
            S_U_SCAN: begin
                if (!r_valid[r_idx] && r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
            end
            S_U_LOAD: begin
                r_e <= r_rd_energy;
                r_t <= (r_now > r_rd_birth) ? r_now - r_rd_birth : 32'd0;
            end
            S_U_K: r_k <= (|r_mul[63:48]) ? RST_ALL : r_mul[47:16];
            S_U_TTR: begin
                r_ttr   <= r_mul[63:16];
                r_coast <= ({16'h0, r_t} > r_mul[63:16]);
            end
            S_U_R1: begin
                r_term <= r_mul[63:16];
                r_rad  <= (|r_mul[63:48]) ? RST_ALL : r_mul[47:16];
            end
            S_U_R2: begin
                if (|(({1'b0, r_term} + {1'b0, r_mul[63:16]}) >> 32))
                    r_rad <= RST_ALL;
                else
                    r_rad <= r_term[31:0] + r_mul[47:16];
            end
            S_U_RR:  r_num <= r_mul[63:16];
            S_U_DEN: r_den <= {1'b0, r_mul[63:16]} + DEN_BIAS;
            S_U_CMP: begin
                r_retire <= (r_rad > r_rmax) ||
                            ((r_rad > FADE_R) && !r_num[47] &&
                             ({r_num, 16'h0} < FADE_DP * {15'h0, r_den}));
            end
            S_U_OUT: begin
                if (emit_ok && more_above) r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status   <= emit_st;
            r_front_id <= emit_id;
            r_radius   <= emit_rad;
            r_last     <= emit_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_front_id = r_front_id;
    assign o_radius   = r_radius;
    assign o_last     = r_last;

endmodule
`default_nettype wire

@@ tb/sv/blast_front_table_test.sv @@
// Self-checking test of blast_front_table: spawn, update and query transactions
// with random idling on both channels, checked against a fixed-point predictor.
// Depends on bft_pkg and blast_front_table.
`default_nettype none
module blast_front_table_test;
    import bft_pkg::*;

    localparam int    FRONTS      = 32;
    localparam int    CYCLE_LIMIT = 10000000;
    localparam int    DRAIN_WAIT  = 300;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ident;
        logic [31:0] radius;
        logic        last;
    } t_front_report;

    class t_front_scoreboard;
        logic [31:0] reg_scale, reg_rho, reg_xi, reg_c0, reg_kp, reg_rmax;
        bit          live [FRONTS];
        logic [31:0] f_id [FRONTS];
        logic [31:0] f_birth [FRONTS];
        logic [31:0] f_energy [FRONTS];
        logic [31:0] f_radius [FRONTS];
        logic [31:0] next_id;
        t_front_report reports_due[$];
        int fails;
        int n_inputs, n_results, n_retired, n_evicted;

        function new();
            reg_scale = RST_ONE; reg_rho = RST_ONE; reg_xi = RST_ONE;
            reg_c0 = RST_ONE; reg_kp = RST_ONE; reg_rmax = RST_ALL;
            foreach (live[i]) live[i] = 0;
            next_id = 32'd1;
            fails = 0; n_inputs = 0; n_results = 0; n_retired = 0; n_evicted = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_ENERGY_SCALE:   reg_scale = v;
                REG_AIR_DENSITY:    reg_rho = v;
                REG_BLAST_CONSTANT: reg_xi = v;
                REG_SOUND_SPEED:    reg_c0 = v;
                REG_PRESSURE_GAIN:  reg_kp = v;
                REG_MAX_RADIUS:     reg_rmax = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // square root of a Q16.16 value of up to 48 bits
        function logic [63:0] q_root(logic [63:0] q);
            return floor_root((q & 64'hFFFF_FFFF_FFFF) << 16);
        endfunction

        function logic [31:0] clip32(logic [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function logic [31:0] blast_radius(logic [31:0] e, logic [31:0] birth,
                                           logic [31:0] now);
            logic [63:0] rho, xi, c0, t, em, q, k, h, ttr;
            rho = (reg_rho == 0) ? 64'd1 : 64'(reg_rho);
            xi  = (reg_xi < XI_FLOOR) ? 64'(XI_FLOOR) : 64'(reg_xi);
            c0  = (reg_c0 < C0_FLOOR) ? 64'(C0_FLOOR) : 64'(reg_c0);
            t   = (now > birth) ? 64'(now - birth) : 64'd0;
            em  = (e < E_FLOOR) ? 64'(E_FLOOR) : 64'(e);
            q   = (em << 16) / rho;
            if (q > 64'hFFFF_FFFF_FFFF) q = 64'hFFFF_FFFF_FFFF;
            k   = 64'(clip32((xi * q_root(q_root(q))) >> 16));
            h   = (k << 16) / (2 * c0);
            ttr = (h * h) >> 16;
            if (t <= ttr) return clip32((k * q_root(t)) >> 16);
            return clip32(((k * q_root(ttr)) >> 16) + ((c0 * (t - ttr)) >> 16));
        endfunction

        function bit pressure_faded(logic [31:0] e, logic [31:0] r);
            logic [63:0] num, den;
            num = (64'(reg_kp) * 64'(e)) >> 16;
            den = ((64'(r) * 64'(r)) >> 16) + 64'(DEN_BIAS);
            if (r <= FADE_R) return 0;
            if ((num >> 47) != 0) return 0;
            return (num << 16) < FADE_DP * den;
        endfunction

        function void due(logic [2:0] st, logic [31:0] id, logic [31:0] r, logic l);
            t_front_report x;
            x.status = st; x.ident = id; x.radius = r; x.last = l;
            reports_due.insert(reports_due.size(), x);
        endfunction

        function void note_input(logic [1:0] kind, logic [31:0] now,
                                 logic [31:0] raw, logic [31:0] qid);
            logic [31:0] e, r;
            int slot, n;
            logic [2:0] st;
            n_inputs++;
            if (kind == KIND_SPAWN) begin
                e = 0;
                if (!raw[31]) e = clip32((64'(raw) * 64'(reg_scale)) >> 16);
                if (e <= E_REJECT_MAX) begin
                    due(ST_REJECT, 32'd0, 32'd0, 1'b1);
                    return;
                end
                slot = -1;
                st = ST_SPAWNED;
                for (int i = 0; i < FRONTS; i++)
                    if (!live[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 1; i < FRONTS; i++)
                        if (f_birth[i] < f_birth[slot]) slot = i;
                    st = ST_EVICTED;
                    n_evicted++;
                end
                live[slot] = 1; f_id[slot] = next_id; f_birth[slot] = now;
                f_energy[slot] = e; f_radius[slot] = 0;
                next_id = next_id + 1;
                if (next_id == 0) next_id = 32'd1;
                due(st, f_id[slot], 32'd0, 1'b1);
            end else if (kind == KIND_UPDATE) begin
                n = 0;
                for (int i = 0; i < FRONTS; i++) begin
                    if (live[i]) begin
                        r = blast_radius(f_energy[i], f_birth[i], now);
                        f_radius[i] = r;
                        st = ST_KEPT;
                        if (r > reg_rmax || pressure_faded(f_energy[i], r)) begin
                            st = ST_RETIRED;
                            live[i] = 0;
                            n_retired++;
                        end
                        due(st, f_id[i], r, 1'b0);
                        n++;
                    end
                end
                if (n == 0) due(ST_EMPTY, 32'd0, 32'd0, 1'b1);
                else reports_due[$].last = 1'b1;
            end else if (kind == KIND_QUERY) begin
                for (int i = 0; i < FRONTS; i++) begin
                    if (live[i] && f_id[i] == qid) begin
                        due(ST_FOUND, qid, f_radius[i], 1'b1);
                        return;
                    end
                end
                due(ST_ABSENT, qid, 32'd0, 1'b1);
            end
        endfunction

        function void check(t_front_report got);
            t_front_report want;
            n_results++;
            if (reports_due.size() == 0) begin
                $error("result with nothing expected: status %0d id %0d",
                       got.status, got.ident);
                fails++;
                return;
            end
            want = reports_due.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.ident !== want.ident) begin
                $error("front id: expected %0d, got %0d", want.ident, got.ident);
                fails++;
            end
            if (got.radius !== want.radius) begin
                $error("radius: expected %h, got %h", want.radius, got.radius);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic                i_clk, i_rst_n;
    logic                i_valid, i_stall;
    logic                o_stall, o_valid;
    logic [1:0]          i_kind;
    logic [31:0]         i_now_time, i_query_id;
    logic signed [31:0]  i_raw_energy;
    logic [2:0]          o_status;
    logic [31:0]         o_front_id, o_radius;
    logic                o_last;
    logic                psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata, prdata;

    t_front_scoreboard sb = new();
    int unsigned send_idle_pct, recv_stall_pct;
    int unsigned cycles;
    logic [31:0] clock_now;

    blast_front_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_now_time(i_now_time),
        .i_raw_energy(i_raw_energy), .i_query_id(i_query_id),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_front_id(o_front_id),
        .o_radius(o_radius), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_valid && !i_stall)
            sb.check('{o_status, o_front_id, o_radius, o_last});
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic send(logic [1:0] kind, logic [31:0] now, logic [31:0] raw,
                        logic [31:0] qid);
        i_valid <= 1; i_kind <= kind; i_now_time <= now;
        i_raw_energy <= raw; i_query_id <= qid;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, now, raw, qid);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // hold until every expected result is in, then let a stray ignored
    // transaction drain before touching the registers
    task automatic drain();
        i_valid <= 0;
        while (sb.reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_energy();
        case ($urandom_range(5))
            0: return $urandom_range(0, 12);
            1: return $urandom_range(13, 4000);
            2: return $urandom_range(32'h1_0000, 32'h40_0000);
            3: return 32'h8000_0000 | $urandom;
            4: return $urandom;
            default: return $urandom_range(32'h100, 32'h2_0000);
        endcase
    endfunction

    task automatic random_items(int count);
        int r;
        logic [31:0] qid;
        for (int n = 0; n < count; n++) begin
            clock_now = clock_now + $urandom_range(0, 32'h6_0000);
            r = $urandom_range(99);
            qid = sb.next_id - $urandom_range(1, 40);
            if ($urandom_range(9) == 0) qid = $urandom;
            if (r < 48)
                send(KIND_SPAWN, ($urandom_range(9) == 0) ? $urandom : clock_now,
                     pick_energy(), $urandom);
            else if (r < 72)
                send(KIND_UPDATE, ($urandom_range(19) == 0) ? $urandom : clock_now,
                     $urandom, $urandom);
            else if (r < 96)
                send(KIND_QUERY, $urandom, $urandom, qid);
            else
                send(KIND_UNUSED, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 3)
            0: begin send_idle_pct = 16; recv_stall_pct = 76; end
            1: begin send_idle_pct = 76; recv_stall_pct = 16; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    initial begin
        cycles = 0;
        clock_now = 32'h10_0000;
        set_idling(0);
        i_rst_n <= 0; i_valid <= 0; i_stall <= 0; i_kind <= KIND_SPAWN;
        i_now_time <= 0; i_raw_energy <= 0; i_query_id <= 0;
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, rejects, field extremes, ignored kind
        send(KIND_UPDATE, 32'h0010_0000, 0, 0);
        send(KIND_QUERY, 0, 0, 32'hFFFF_FFFF);
        send(KIND_SPAWN, 32'h0000_0000, 32'h8000_0000, 0);
        send(KIND_SPAWN, 32'h0001_0000, 32'd6, 0);
        send(KIND_SPAWN, 32'h0001_0000, 32'd0, 0);
        send(KIND_SPAWN, 32'h0001_0000, 32'hFFFF_FFFF, 0);
        send(KIND_SPAWN, 32'h0002_0000, 32'd7, 0);
        send(KIND_SPAWN, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send(KIND_SPAWN, 32'h0003_0000, 32'h0004_0000, 0);
        send(KIND_QUERY, 0, 0, 32'd1);
        send(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_UPDATE, 32'h0000_0000, 0, 0);
        send(KIND_UPDATE, 32'h0004_0000, 0, 0);
        send(KIND_QUERY, 0, 0, 32'd2);
        send(KIND_QUERY, 0, 0, 32'd0);
        send(KIND_UPDATE, 32'hFFFF_FFFF, 0, 0);
        send(KIND_QUERY, 0, 0, 32'd3);
        random_items(35);
        drain();

        // extremes low/high, then the opposite corner, then random settings
        for (int ph = 1; ph < 4; ph++) begin
            set_idling((ph > 2) ? 2 : ph);
            case (ph)
                1: begin
                    write_reg(REG_ENERGY_SCALE, 32'hFFFF_FFFF);
                    write_reg(REG_AIR_DENSITY, 32'd0);
                    write_reg(REG_BLAST_CONSTANT, 32'd0);
                    write_reg(REG_SOUND_SPEED, 32'd0);
                    write_reg(REG_PRESSURE_GAIN, 32'd0);
                    write_reg(REG_MAX_RADIUS, 32'h0040_0000);
                end
                2: begin
                    write_reg(REG_ENERGY_SCALE, 32'h0000_8000);
                    write_reg(REG_AIR_DENSITY, 32'hFFFF_FFFF);
                    write_reg(REG_BLAST_CONSTANT, 32'hFFFF_FFFF);
                    write_reg(REG_SOUND_SPEED, 32'hFFFF_FFFF);
                    write_reg(REG_PRESSURE_GAIN, 32'hFFFF_FFFF);
                    write_reg(REG_MAX_RADIUS, 32'd0);
                end
                default: begin
                    write_reg(REG_ENERGY_SCALE, $urandom_range(32'h100, 32'h4_0000));
                    write_reg(REG_AIR_DENSITY, $urandom_range(1, 32'h4_0000));
                    write_reg(REG_BLAST_CONSTANT, $urandom_range(0, 32'h4_0000));
                    write_reg(REG_SOUND_SPEED, $urandom_range(0, 32'h8_0000));
                    write_reg(REG_PRESSURE_GAIN, $urandom_range(0, 32'h100));
                    write_reg(REG_MAX_RADIUS, $urandom);
                end
            endcase
            random_items(45);
            drain();
        end

        $display("covered %0d transactions in, %0d results out, %0d evictions, %0d retirements",
                 sb.n_inputs, sb.n_results, sb.n_evicted, sb.n_retired);
        if (sb.fails == 0 && sb.reports_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
